@@ hw/rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table depth, field widths, request and status codes, and the control
// struct that the controller broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package skt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed item field widths
  localparam int REQ_W = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int POS_W = 4;
  localparam int ENT_W = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins;   // open a slot at the insert point and write the new pair
    logic rmv;   // close the gap at the first match
  } ctl_t;

endpackage

@@ hw/rtl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key table
// Holds one key/data pair, compares it against the request key when an item
// is accepted, and on update either keeps its pair or takes the pair of its
// left or right neighbor, or the new pair.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                              clk,
  input  logic                              cmp_en,
  input  logic                              occupied,
  input  logic signed [skt_pkg::KEY_W-1:0]  cmp_key,
  input  skt_pkg::ctl_t                     ctl,
  input  logic signed [skt_pkg::KEY_W-1:0]  new_key,
  input  logic signed [skt_pkg::VAL_W-1:0]  new_value,
  input  logic                              left_at,
  input  logic signed [skt_pkg::KEY_W-1:0]  left_key,
  input  logic signed [skt_pkg::VAL_W-1:0]  left_value,
  input  logic signed [skt_pkg::KEY_W-1:0]  right_key,
  input  logic signed [skt_pkg::VAL_W-1:0]  right_value,
  input  logic                              seen_in,
  output logic                              seen_out,
  input  logic signed [skt_pkg::KEY_W-1:0]  fnd_key_in,
  input  logic signed [skt_pkg::VAL_W-1:0]  fnd_value_in,
  output logic signed [skt_pkg::KEY_W-1:0]  fnd_key_out,
  output logic signed [skt_pkg::VAL_W-1:0]  fnd_value_out,
  output logic                              at,
  output logic                              eq,
  output logic signed [skt_pkg::KEY_W-1:0]  cell_key,
  output logic signed [skt_pkg::VAL_W-1:0]  cell_value
);
  import skt_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    at_r;
  logic                    at_nxt;
  logic                    eq_r;
  logic                    eq_nxt;

  // compare: at marks "insert point is here or to the left", eq marks a match
  always_comb begin
    at_nxt = !occupied || (cmp_key < key_r);
    eq_nxt = occupied && (cmp_key == key_r);
  end

  // latch compare flags with the accepted item
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      at_r <= at_nxt;
      eq_r <= eq_nxt;
    end
  end

  // first-match chain: pass the matched pair toward the end of the row
  always_comb begin
    seen_out      = seen_in || eq_r;
    fnd_key_out   = (eq_r && !seen_in) ? key_r   : fnd_key_in;
    fnd_value_out = (eq_r && !seen_in) ? value_r : fnd_value_in;
  end

  // pick the next pair: shift right on insert, shift left on remove
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctl.ins) begin
      if (left_at) begin
        key_nxt   = left_key;
        value_nxt = left_value;
      end else if (at_r) begin
        key_nxt   = new_key;
        value_nxt = new_value;
      end
    end else if (ctl.rmv && seen_out) begin
      key_nxt   = right_key;
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign at         = at_r;
  assign eq         = eq_r;
  assign cell_key   = key_r;
  assign cell_value = value_r;

endmodule

@@ hw/rtl/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table: key/data table kept in ascending signed key order
// Insert, search and remove requests over a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// For each item, at the accept edge every cell compares the request key with
// its own key and stores the result; in the update cycle the controller
// resolves the insert point or first match from those flags, the cells from
// that point on shift one place at once on insert or remove, and the result
// item is loaded into the output register. The input stalls during the update
// cycle, so a new item is taken at the earliest in the cycle after the
// previous item's update; none is taken before the previous one is through.
// While the output register holds a result that has not been taken, the update
// cycle waits, and the input stays stalled with it. Inserts place the pair
// after any equal keys; search and remove act on the lowest matching entry.
// Contents after reset are empty (entry count zero), no clearing pass.
module sorted_key_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [skt_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [skt_pkg::KEY_W-1:0] in_key,
  input  logic signed [skt_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [skt_pkg::STS_W-1:0]        out_status,
  output logic [skt_pkg::POS_W-1:0]        out_position,
  output logic signed [skt_pkg::KEY_W-1:0] out_found_key,
  output logic signed [skt_pkg::VAL_W-1:0] out_found_value,
  output logic [skt_pkg::ENT_W-1:0]        out_entries
);
  import skt_pkg::*;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [REQ_W-1:0]        req_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [STS_W-1:0]        status_r;
  logic [STS_W-1:0]        status_nxt;
  logic [POS_W-1:0]        position_r;
  logic [POS_W-1:0]        position_nxt;
  logic signed [KEY_W-1:0] fkey_r;
  logic signed [KEY_W-1:0] fkey_nxt;
  logic signed [VAL_W-1:0] fval_r;
  logic signed [VAL_W-1:0] fval_nxt;
  logic [ENT_W-1:0]        entries_r;
  logic [ENT_W-1:0]        entries_nxt;

  logic                    in_accept;
  logic                    out_free;
  logic                    upd_go;
  logic                    full;
  logic                    found;
  logic [IDX_W-1:0]        ins_pos;
  logic [IDX_W-1:0]        rm_pos;
  ctl_t                    ctl;

  logic [TABLE_DEPTH-1:0]  occ;
  logic [TABLE_DEPTH-1:0]  at_w;
  logic [TABLE_DEPTH-1:0]  eq_w;
  logic [TABLE_DEPTH:0]    seen_w;
  logic signed [KEY_W-1:0] cell_key_w   [TABLE_DEPTH];
  logic signed [VAL_W-1:0] cell_value_w [TABLE_DEPTH];
  logic signed [KEY_W-1:0] fnd_key_w    [TABLE_DEPTH+1];
  logic signed [VAL_W-1:0] fnd_value_w  [TABLE_DEPTH+1];

  // handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign upd_go    = (state_r == ST_UPD) && out_free;

  // hold the accepted item for the update cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_req_type;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // row of cells
  assign seen_w[0]      = 1'b0;
  assign fnd_key_w[0]   = '0;
  assign fnd_value_w[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                    l_at;
    logic signed [KEY_W-1:0] l_key;
    logic signed [VAL_W-1:0] l_value;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;

    assign occ[g] = (count_r > CNT_W'(g));

    if (g == 0) begin : g_first
      assign l_at    = 1'b0;
      assign l_key   = key_r;
      assign l_value = val_r;
    end else begin : g_mid
      assign l_at    = at_w[g-1];
      assign l_key   = cell_key_w[g-1];
      assign l_value = cell_value_w[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign r_key   = cell_key_w[g];
      assign r_value = cell_value_w[g];
    end else begin : g_inner
      assign r_key   = cell_key_w[g+1];
      assign r_value = cell_value_w[g+1];
    end

    skt_cell u_cell (
      .clk           (clk),
      .cmp_en        (in_accept),
      .occupied      (occ[g]),
      .cmp_key       (in_key),
      .ctl           (ctl),
      .new_key       (key_r),
      .new_value     (val_r),
      .left_at       (l_at),
      .left_key      (l_key),
      .left_value    (l_value),
      .right_key     (r_key),
      .right_value   (r_value),
      .seen_in       (seen_w[g]),
      .seen_out      (seen_w[g+1]),
      .fnd_key_in    (fnd_key_w[g]),
      .fnd_value_in  (fnd_value_w[g]),
      .fnd_key_out   (fnd_key_w[g+1]),
      .fnd_value_out (fnd_value_w[g+1]),
      .at            (at_w[g]),
      .eq            (eq_w[g]),
      .cell_key      (cell_key_w[g]),
      .cell_value    (cell_value_w[g])
    );
  end

  // locate insert point and first match from the cell flags
  always_comb begin
    ins_pos = '0;
    rm_pos  = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (at_w[i]) ins_pos = IDX_W'(i);
      if (eq_w[i]) rm_pos  = IDX_W'(i);
    end
  end

  assign full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign found = seen_w[TABLE_DEPTH];

  // next state, cell command and result item
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    position_nxt  = position_r;
    fkey_nxt      = fkey_r;
    fval_nxt      = fval_r;
    entries_nxt   = entries_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          position_nxt  = '0;
          fkey_nxt      = '0;
          fval_nxt      = '0;
          case (req_r)
            REQ_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.ins      = 1'b1;
                position_nxt = POS_W'(ins_pos);
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            REQ_SEARCH, REQ_REMOVE: begin
              if (!found) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                position_nxt = POS_W'(rm_pos);
                fkey_nxt     = fnd_key_w[TABLE_DEPTH];
                fval_nxt     = fnd_value_w[TABLE_DEPTH];
                if (req_r == REQ_REMOVE) begin
                  ctl.rmv   = 1'b1;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
          entries_nxt = ENT_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    position_r <= position_nxt;
    fkey_r     <= fkey_nxt;
    fval_r     <= fval_nxt;
    entries_r  <= entries_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = position_r;
  assign out_found_key   = fkey_r;
  assign out_found_value = fval_r;
  assign out_entries     = entries_r;

  // accepted item always goes to the update cycle
  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_UPD))
    else $error("accepted item did not enter update");

  // a new result only appears after an update cycle
  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go == 1'b0 && !(out_valid_r && out_stall)) |=> !out_valid_r)
    else $error("result shown without update");

  // insert grows the table by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow entry count");

  // remove shrinks the table by one
  a_rmv_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rmv |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove did not shrink entry count");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |-> (count_r < CNT_W'(TABLE_DEPTH)))
    else $error("insert into full table");

endmodule
